FILE: sv/pod_pkg.sv
`default_nettype none
package pod_pkg;

   localparam int MAX_POLYGONS = 64;
   localparam int COORD_BITS   = 16;

   localparam int ADDR_BITS  = $clog2(MAX_POLYGONS);
   localparam int COUNT_BITS = $clog2(MAX_POLYGONS + 1);
   localparam int ROOT_BITS  = COORD_BITS + 1;
   localparam int VAL_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 3;
   localparam int STEP_BITS  = $clog2(ROOT_BITS);
   localparam int COST_BITS  = 32;
   localparam int FIELD_BITS = 16;
   localparam int MASK_BITS  = 64;
   localparam int MIDX_BITS  = 6;
   localparam int PCNT_BITS  = 7;
   localparam int NUM_DIST   = 4;

   localparam logic [COST_BITS-1:0] COST_MAX = '1;

   localparam logic [7:0] REG_DEPOT_X = 8'd0;
   localparam logic [7:0] REG_DEPOT_Y = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_ADD,
      ST_CMP,
      ST_TR_INIT,
      ST_TR_READ,
      ST_TR_STEP,
      ST_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_DIFF,
      DS_SQ,
      DS_ROOT
   } dist_state_type;

   function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                    input logic [COST_BITS-1:0] b);
      logic [COST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: sv/path_orientation_dp_top.sv
`default_nettype none
// Orientation chooser for a fixed visiting order of polygons.
//
// req_ channel: one polygon per transaction, two endpoints in tdata, tlast
// marks the final polygon of the order. rsp_ channel: one transaction per
// order, sent after its final polygon: least cost, reversal mask and count in
// tdata, tuser flags dropped polygons. csr_ channel: depot x (index 0) and
// depot y (index 1); always ready, write only while the block is idle.
//
// Each polygon runs through these steps before the next one is accepted: the
// accept, the start of the four distance units that run side by side, the
// difference and squares, a bit-serial square root, the done strobe, then
// the add and the compare.
// A polygon beyond capacity is dropped at its accept. On the final polygon
// a traceback walks the back-pointer RAM, a read and a step state per
// polygon to wait out the RAM read, then the result goes to the output register.
//
// Reset clears the costs, count, depot and output valid flag; the pointer RAM
// is not cleared, every entry is written before it is read. A stalled
// receiver holds the result; the next order may already be accepted and is
// computed, its own result waits until the register frees.
module path_orientation_dp_top import pod_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   // first_x, first_y, second_x, second_y (16 bits each) from bit 0 up
   input  wire logic [63:0]  req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // total_cost [31:0], reversed_mask [95:32], polygon_count [102:96], zero pad
   output logic      [103:0] rsp_tdata,
   // overflow
   output logic              rsp_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   top_state_type state_ff, state_in;

   logic [COORD_BITS-1:0] depot_x_ff, depot_x_in, depot_y_ff, depot_y_in;
   logic [COORD_BITS-1:0] fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in, sy_ff, sy_in;
   logic                  last_ff, last_in;
   logic [COORD_BITS-1:0] pfx_ff, pfx_in, pfy_ff, pfy_in, psx_ff, psx_in, psy_ff, psy_in;
   logic [COST_BITS-1:0]  cf_ff, cf_in, cr_ff, cr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [COST_BITS-1:0]  sum_ff [NUM_DIST];
   logic [COST_BITS-1:0]  sum_in [NUM_DIST];
   logic                  dir_ff, dir_in;
   logic [ADDR_BITS-1:0]  idx_ff, idx_in;
   logic [MASK_BITS-1:0]  mask_ff, mask_in;
   logic [COST_BITS-1:0]  total_ff, total_in;
   logic [103:0]          rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_fire;
   logic                  dist_start;
   logic [COORD_BITS-1:0] src_x [NUM_DIST];
   logic [COORD_BITS-1:0] src_y [NUM_DIST];
   logic [COORD_BITS-1:0] dst_x [NUM_DIST];
   logic [COORD_BITS-1:0] dst_y [NUM_DIST];
   logic [ROOT_BITS-1:0]  dist_val [NUM_DIST];
   logic [NUM_DIST-1:0]   dist_done;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [1:0]            ram_wdata;
   logic [1:0]            ram_rdata;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // units 0/1 leave the depot or the previous forward exit, 2/3 the
   // previous reversed exit; even units enter at first, odd at second
   always_comb begin
      src_x[0] = (count_ff == '0) ? depot_x_ff : psx_ff;
      src_y[0] = (count_ff == '0) ? depot_y_ff : psy_ff;
      src_x[1] = src_x[0];
      src_y[1] = src_y[0];
      src_x[2] = pfx_ff;
      src_y[2] = pfy_ff;
      src_x[3] = pfx_ff;
      src_y[3] = pfy_ff;
      dst_x[0] = fx_ff;
      dst_y[0] = fy_ff;
      dst_x[1] = sx_ff;
      dst_y[1] = sy_ff;
      dst_x[2] = fx_ff;
      dst_y[2] = fy_ff;
      dst_x[3] = sx_ff;
      dst_y[3] = sy_ff;
   end

   for (genvar g = 0; g < NUM_DIST; g++) begin : g_dist
      pod_dist u_dist (
         .clock (clock),
         .reset (reset),
         .start (dist_start),
         .ax    (src_x[g]),
         .ay    (src_y[g]),
         .bx    (dst_x[g]),
         .by    (dst_y[g]),
         .root  (dist_val[g]),
         .done  (dist_done[g])
      );
   end

   pod_ram #(
      .WIDTH (2),
      .DEPTH (MAX_POLYGONS)
   ) u_bp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depot_x_ff   <= '0;
         depot_y_ff   <= '0;
         pfx_ff       <= '0;
         pfy_ff       <= '0;
         psx_ff       <= '0;
         psy_ff       <= '0;
         cf_ff        <= '0;
         cr_ff        <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depot_x_ff   <= depot_x_in;
         depot_y_ff   <= depot_y_in;
         pfx_ff       <= pfx_in;
         pfy_ff       <= pfy_in;
         psx_ff       <= psx_in;
         psy_ff       <= psy_in;
         cf_ff        <= cf_in;
         cr_ff        <= cr_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      last_ff     <= last_in;
      sum_ff      <= sum_in;
      dir_ff      <= dir_in;
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      depot_x_in   = depot_x_ff;
      depot_y_in   = depot_y_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      last_in      = last_ff;
      pfx_in       = pfx_ff;
      pfy_in       = pfy_ff;
      psx_in       = psx_ff;
      psy_in       = psy_ff;
      cf_in        = cf_ff;
      cr_in        = cr_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      dir_in       = dir_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      total_in     = total_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dist_start   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = ADDR_BITS'(count_ff);
      ram_wdata    = 2'b00;

      // configuration writes land in any state
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_DEPOT_X) depot_x_in = COORD_BITS'(csr_data);
         if (csr_index == REG_DEPOT_Y) depot_y_in = COORD_BITS'(csr_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fx_in   = COORD_BITS'(req_tdata[15:0]);
               fy_in   = COORD_BITS'(req_tdata[31:16]);
               sx_in   = COORD_BITS'(req_tdata[47:32]);
               sy_in   = COORD_BITS'(req_tdata[63:48]);
               last_in = req_tlast;
               if (count_ff == COUNT_BITS'(MAX_POLYGONS)) begin
                  // drop the polygon, keep the path
                  ovf_in   = 1'b1;
                  state_in = req_tlast ? ST_TR_INIT : ST_IDLE;
               end else begin
                  state_in = ST_DIST;
               end
            end
         end
         ST_DIST: begin
            // start fires in the cycle after the fields are latched
            dist_start = !dist_done[0] && (fx_ff == fx_in);
            if (dist_done[0]) state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in[0] = sat_add(cf_ff, COST_BITS'(dist_val[0]));
            sum_in[1] = sat_add(cf_ff, COST_BITS'(dist_val[1]));
            sum_in[2] = sat_add(cr_ff, COST_BITS'(dist_val[2]));
            sum_in[3] = sat_add(cr_ff, COST_BITS'(dist_val[3]));
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            ram_we = 1'b1;
            if (count_ff == '0) begin
               cf_in = COST_BITS'(dist_val[0]);
               cr_in = COST_BITS'(dist_val[1]);
            end else begin
               // forward predecessor wins a tie
               cf_in        = (sum_ff[2] < sum_ff[0]) ? sum_ff[2] : sum_ff[0];
               cr_in        = (sum_ff[3] < sum_ff[1]) ? sum_ff[3] : sum_ff[1];
               ram_wdata[0] = (sum_ff[2] < sum_ff[0]);
               ram_wdata[1] = (sum_ff[3] < sum_ff[1]);
            end
            pfx_in   = fx_ff;
            pfy_in   = fy_ff;
            psx_in   = sx_ff;
            psy_in   = sy_ff;
            count_in = count_ff + 1'b1;
            state_in = last_ff ? ST_TR_INIT : ST_IDLE;
         end
         ST_TR_INIT: begin
            dir_in   = (cr_ff < cf_ff);
            total_in = (cr_ff < cf_ff) ? cr_ff : cf_ff;
            idx_in   = ADDR_BITS'(count_ff - 1'b1);
            mask_in  = '0;
            state_in = ST_TR_READ;
         end
         ST_TR_READ: begin
            // wait out the RAM read of the current polygon's pointers
            state_in = ST_TR_STEP;
         end
         ST_TR_STEP: begin
            mask_in[MIDX_BITS'(idx_ff)] = dir_ff;
            if (idx_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               dir_in   = ram_rdata[dir_ff];
               idx_in   = idx_ff - 1'b1;
               state_in = ST_TR_READ;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {1'b0, PCNT_BITS'(count_ff), mask_ff, total_ff};
               rsp_user_in  = ovf_ff;
               rsp_valid_in = 1'b1;
               // clear the path for the next order
               cf_in    = '0;
               cr_in    = '0;
               pfx_in   = '0;
               pfy_in   = '0;
               psx_in   = '0;
               psy_in   = '0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_POLYGONS))
      else $error("polygon count beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == COUNT_BITS'(MAX_POLYGONS))
      else $error("overflow flagged before capacity reached");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[102:96] != '0)
      else $error("result with no polygon");

   a_units_lock: assert property (@(posedge clock) disable iff (reset)
      dist_done[0] |-> (&dist_done))
      else $error("distance units out of step");

   a_done_in_dist: assert property (@(posedge clock) disable iff (reset)
      dist_done[0] |-> state_ff == ST_DIST)
      else $error("distance finished outside the distance phase");
endmodule
`default_nettype wire

FILE: sv/pod_ram.sv
`default_nettype none
module pod_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: sv/pod_dist.sv
`default_nettype none
module pod_dist import pod_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] ax,
   input  wire logic [COORD_BITS-1:0] ay,
   input  wire logic [COORD_BITS-1:0] bx,
   input  wire logic [COORD_BITS-1:0] by,
   output logic      [ROOT_BITS-1:0]  root,
   output logic                       done
);
   dist_state_type state_ff, state_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [VAL_BITS-1:0]   val_ff, val_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  done_ff, done_in;
   logic [REM_BITS-1:0]   shifted, trial;
   logic [2*COORD_BITS-1:0] sq_x, sq_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign sq_x = dx_ff * dx_ff;
   assign sq_y = dy_ff * dy_ff;

   // two radicand bits enter the remainder each cycle
   assign shifted = {rem_ff[REM_BITS-3:0], val_ff[VAL_BITS-1 -: 2]};
   assign trial   = REM_BITS'({root_ff, 2'b01});

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DS_IDLE: begin
            if (start) state_in = DS_DIFF;
         end
         DS_DIFF: begin
            dx_in    = (ax > bx) ? ax - bx : bx - ax;
            dy_in    = (ay > by) ? ay - by : by - ay;
            state_in = DS_SQ;
         end
         DS_SQ: begin
            val_in   = VAL_BITS'(sq_x) + VAL_BITS'(sq_y);
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = DS_ROOT;
         end
         DS_ROOT: begin
            val_in = {val_ff[VAL_BITS-3:0], 2'b00};
            if (shifted >= trial) begin
               rem_in  = shifted - trial;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               done_in  = 1'b1;
               state_in = DS_IDLE;
            end
         end
         default: state_in = DS_IDLE;
      endcase
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: bench/tb_path_orientation_dp_top.sv
`default_nettype none
module tb_path_orientation_dp_top;
   import pod_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 2000;

   typedef struct packed {
      logic [31:0] cost;
      logic [63:0] mask;
      logic [6:0]  count;
      logic        dropped;
   } tour_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [63:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   // Orientation state mirrored from the block: two running path costs, the
   // exits of the previous polygon, per-polygon turn bits, count and drop flag.
   logic [15:0] depot_x, depot_y;
   logic [31:0] path_fwd, path_rev;
   logic [15:0] prev_fx, prev_fy, prev_sx, prev_sy;
   logic [1:0]  turn_bits [0:MAX_POLYGONS-1];
   int          taken;
   logic        dropped;

   tour_type tours_due [$];
   int    mismatches = 0;

   // Sender and receiver idling knobs.
   bit  sender_busy_mode = 1'b1;
   bit  receiver_busy_mode = 1'b1;
   int  hold_requests = 0;
   int  holds_started = 0;
   int  hold_left = 0;
   int  recv_idle_left = 0;
   int  quiet_cycles = 0;

   path_orientation_dp_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[31:0];
   endfunction

   function automatic logic [31:0] hop(logic [15:0] ax, logic [15:0] ay,
                                       logic [15:0] bx, logic [15:0] by);
      logic [63:0] dx, dy;
      dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
      dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
      return floor_root(dx * dx + dy * dy);
   endfunction

   function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   task automatic clear_tour();
      path_fwd = 0;
      path_rev = 0;
      prev_fx = 0;
      prev_fy = 0;
      prev_sx = 0;
      prev_sy = 0;
      taken = 0;
      dropped = 1'b0;
   endtask

   // Advance the orientation state by one polygon; queue the tour on the last.
   task automatic orient_polygon(logic [15:0] fx, logic [15:0] fy,
                                 logic [15:0] sx, logic [15:0] sy, logic last);
      logic [31:0] nf, cf, nr, cr;
      logic [1:0]  tb;
      logic        dir;
      tour_type    t;
      int          i;
      if (taken >= MAX_POLYGONS) begin
         dropped = 1'b1;
      end else begin
         if (taken == 0) begin
            path_fwd = hop(depot_x, depot_y, fx, fy);
            path_rev = hop(depot_x, depot_y, sx, sy);
            turn_bits[0] = 2'b00;
         end else begin
            // forward exits at second endpoint, reversed exits at first
            nf = add_clamped(path_fwd, hop(prev_sx, prev_sy, fx, fy));
            cf = add_clamped(path_rev, hop(prev_fx, prev_fy, fx, fy));
            nr = add_clamped(path_fwd, hop(prev_sx, prev_sy, sx, sy));
            cr = add_clamped(path_rev, hop(prev_fx, prev_fy, sx, sy));
            tb = 2'b00;
            if (cf < nf) begin nf = cf; tb[0] = 1'b1; end
            if (cr < nr) begin nr = cr; tb[1] = 1'b1; end
            path_fwd = nf;
            path_rev = nr;
            turn_bits[taken] = tb;
         end
         taken++;
         prev_fx = fx;
         prev_fy = fy;
         prev_sx = sx;
         prev_sy = sy;
      end
      if (last) begin
         dir = (path_fwd <= path_rev) ? 1'b0 : 1'b1;
         t.cost = dir ? path_rev : path_fwd;
         t.mask = '0;
         for (i = taken - 1; i >= 0; i--) begin
            if (dir) t.mask[i] = 1'b1;
            if (i > 0) dir = turn_bits[i][dir];
         end
         t.count = 7'(taken);
         t.dropped = dropped;
         tours_due.insert(tours_due.size(), t);
         clear_tour();
      end
   endtask

   // ---------------- checking ----------------

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0h actual %0h", what, want, got);
   endtask

   always @(posedge clock) begin
      tour_type t;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tours_due.size() == 0) begin
            report_mismatch("unexpected result, cost", 0, rsp_tdata[31:0]);
         end else begin
            t = tours_due.pop_front();
            if (rsp_tdata[31:0] !== t.cost)
               report_mismatch("total_cost", t.cost, rsp_tdata[31:0]);
            if (rsp_tdata[95:32] !== t.mask)
               report_mismatch("reversed_mask", t.mask, rsp_tdata[95:32]);
            if (rsp_tdata[102:96] !== t.count)
               report_mismatch("polygon_count", t.count, rsp_tdata[102:96]);
            if (rsp_tuser !== t.dropped)
               report_mismatch("overflow", t.dropped, rsp_tuser);
         end
      end
   end

   // Receiver: random stalls, plus long holds counted here on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_started != hold_requests) begin
         holds_started <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (recv_idle_left > 0) begin
         recv_idle_left <= recv_idle_left - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_busy_mode && $urandom_range(0, 99) < 15) begin
         recv_idle_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic int sender_gap();
      if (!sender_busy_mode || $urandom_range(0, 99) < 70) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 50);
      return $urandom_range(1, 3);
   endfunction

   // Offer one polygon, hold until accepted, then predict it.
   task automatic send_polygon(logic [15:0] fx, logic [15:0] fy,
                               logic [15:0] sx, logic [15:0] sy, logic last);
      int gap;
      req_tdata <= {sy, sx, fy, fx};
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      orient_polygon(fx, fy, sx, sy, last);
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every tour is out and the block is quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tours_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] index, logic [15:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_DEPOT_X) depot_x = value;
      else if (index == REG_DEPOT_Y) depot_y = value;
   endtask

   task automatic set_depot(logic [15:0] x, logic [15:0] y);
      drain();
      write_reg(REG_DEPOT_X, x);
      write_reg(REG_DEPOT_Y, y);
   endtask

   // Mix of extremes, tight clusters (for ties) and full-range values.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'h8000 + 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random_order(int len);
      int i;
      for (i = 0; i < len; i++)
         send_polygon(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      i == len - 1);
   endtask

   // ---------------- tests ----------------

   task automatic test_single_polygons();
      send_polygon(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_polygon(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
      send_polygon(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
      send_polygon(16'h1234, 16'h5678, 16'h1234, 16'h5678, 1'b1);
   endtask

   task automatic test_short_orders();
      set_depot(16'hFFFF, 16'hFFFF);
      send_polygon(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      send_polygon(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      send_polygon(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
      // equal endpoints: every comparison ties
      send_polygon(16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b0);
      send_polygon(16'h0200, 16'h0200, 16'h0200, 16'h0200, 1'b1);
      // mirror-symmetric polygons tie both directions
      send_polygon(16'h0000, 16'h0010, 16'h0010, 16'h0000, 1'b0);
      send_polygon(16'h0000, 16'h0010, 16'h0010, 16'h0000, 1'b1);
   endtask

   task automatic test_capacity();
      int i;
      set_depot(16'h0000, 16'h0000);
      sender_busy_mode = 1'b0;
      // beyond capacity: last item itself is dropped
      for (i = 0; i < MAX_POLYGONS + 2; i++)
         send_polygon(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      i == MAX_POLYGONS + 1);
      send_random_order(MAX_POLYGONS);
      sender_busy_mode = 1'b1;
   endtask

   task automatic test_back_pressure();
      int i;
      set_depot(16'h4000, 16'hC000);
      sender_busy_mode = 1'b0;
      hold_requests <= hold_requests + 1;
      for (i = 0; i < 6; i++) send_random_order(3);
      sender_busy_mode = 1'b1;
   endtask

   task automatic test_random_orders(int items);
      int sent;
      int len;
      int roll;
      sent = 0;
      while (sent < items) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) len = $urandom_range(1, 12);
         else if (roll < 96) len = $urandom_range(13, 63);
         else len = $urandom_range(MAX_POLYGONS, MAX_POLYGONS + 4);
         send_random_order(len);
         sent += len;
      end
   endtask

   initial begin
      clear_tour();
      depot_x = 0;
      depot_y = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_polygons();
      test_short_orders();
      test_capacity();
      test_back_pressure();

      set_depot(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      test_random_orders(300);
      receiver_busy_mode = 1'b0;
      sender_busy_mode = 1'b0;
      set_depot(16'h0000, 16'hFFFF);
      test_random_orders(250);
      receiver_busy_mode = 1'b1;
      sender_busy_mode = 1'b1;
      set_depot(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      test_random_orders(300);

      drain();
      if (mismatches == 0 && tours_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
sv/pod_pkg.sv
sv/pod_ram.sv
sv/pod_dist.sv
sv/path_orientation_dp_top.sv
bench/tb_path_orientation_dp_top.sv
